>>> src/owb_pkg.sv
`timescale 1ns / 1ps
// Package: shared types, command codes and register defaults for the 1-Wire master.
package owb_pkg;

  // Counter width default; the top level hands this down as COUNT_BITS.
  localparam int COUNT_BITS_DEF = 10;

  // Configuration register geometry.
  localparam int REG_BITS  = 10;
  localparam int REG_COUNT = 7;
  localparam int IDX_BITS  = 3;

  // Register indexes.
  localparam logic [IDX_BITS-1:0] REG_RESET_LOW_TIME    = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_PRESENCE_WAIT     = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_RESET_TAIL        = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_SLOT_LOW_TIME     = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_WRITE_HOLD        = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_READ_SAMPLE_DELAY = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_READ_TAIL         = 3'd6;

  // Register reset values, in ticks.
  localparam logic [REG_BITS-1:0] RST_RESET_LOW_TIME    = 10'd480;
  localparam logic [REG_BITS-1:0] RST_PRESENCE_WAIT     = 10'd70;
  localparam logic [REG_BITS-1:0] RST_RESET_TAIL        = 10'd410;
  localparam logic [REG_BITS-1:0] RST_SLOT_LOW_TIME     = 10'd2;
  localparam logic [REG_BITS-1:0] RST_WRITE_HOLD        = 10'd60;
  localparam logic [REG_BITS-1:0] RST_READ_SAMPLE_DELAY = 10'd10;
  localparam logic [REG_BITS-1:0] RST_READ_TAIL         = 10'd50;

  // Command codes carried by an input beat.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       line_level;
  } owb_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } owb_out_t;

  // Raw timing registers as seen by the engine.
  typedef struct packed {
    logic [REG_BITS-1:0] reset_low_time;
    logic [REG_BITS-1:0] presence_wait;
    logic [REG_BITS-1:0] reset_tail;
    logic [REG_BITS-1:0] slot_low_time;
    logic [REG_BITS-1:0] write_hold;
    logic [REG_BITS-1:0] read_sample_delay;
    logic [REG_BITS-1:0] read_tail;
  } owb_cfg_t;

endpackage

>>> src/owb_cfg_regs.sv
`timescale 1ns / 1ps
// Timing register file: seven write-only tick counts with reset defaults.
module owb_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [owb_pkg::IDX_BITS-1:0]  wr_index,
  input  logic [owb_pkg::REG_BITS-1:0]  wr_data,
  output owb_pkg::owb_cfg_t             cfg
);
  import owb_pkg::*;

  owb_cfg_t cfg_r;
  owb_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_RESET_LOW_TIME:    cfg_nxt.reset_low_time    = wr_data;
        REG_PRESENCE_WAIT:     cfg_nxt.presence_wait     = wr_data;
        REG_RESET_TAIL:        cfg_nxt.reset_tail        = wr_data;
        REG_SLOT_LOW_TIME:     cfg_nxt.slot_low_time     = wr_data;
        REG_WRITE_HOLD:        cfg_nxt.write_hold        = wr_data;
        REG_READ_SAMPLE_DELAY: cfg_nxt.read_sample_delay = wr_data;
        REG_READ_TAIL:         cfg_nxt.read_tail         = wr_data;
        default:               cfg_nxt = cfg_r; // index past the list: drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_time    <= RST_RESET_LOW_TIME;
      cfg_r.presence_wait     <= RST_PRESENCE_WAIT;
      cfg_r.reset_tail        <= RST_RESET_TAIL;
      cfg_r.slot_low_time     <= RST_SLOT_LOW_TIME;
      cfg_r.write_hold        <= RST_WRITE_HOLD;
      cfg_r.read_sample_delay <= RST_READ_SAMPLE_DELAY;
      cfg_r.read_tail         <= RST_READ_TAIL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/owb_engine.sv
`timescale 1ns / 1ps
// Bus sequencer: phase state machine, tick counter, bit shifter and result logic.
module owb_engine #(
  parameter int COUNT_BITS = owb_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat_en,
  input  owb_pkg::owb_in_t  beat,
  input  owb_pkg::owb_cfg_t cfg,
  output owb_pkg::owb_out_t res
);
  import owb_pkg::*;

  // Compare width covers both the counter and the raw register.
  localparam int LW = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;
  localparam logic [LW-1:0] CMAX = LW'((1 << COUNT_BITS) - 1);

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_RST_LOW   = 7'b0000010,
    PH_RST_WAIT  = 7'b0000100,
    PH_RST_TAIL  = 7'b0001000,
    PH_SLOT_LOW  = 7'b0010000,
    PH_SLOT_MID  = 7'b0100000,
    PH_READ_TAIL = 7'b1000000
  } owb_phase_t;

  owb_phase_t              phase_r, phase_nxt;
  logic [COUNT_BITS-1:0]   tick_r, tick_nxt;
  logic [7:0]              shift_r, shift_nxt;
  logic [2:0]              bit_r, bit_nxt;
  logic                    reading_r, reading_nxt;
  logic                    presence_r, presence_nxt;

  logic [COUNT_BITS-1:0]   tick_inc;
  logic [LW-1:0]           tick_cmp;
  logic                    done;
  logic                    rej;

  // Phase length: zero bumps to one where required, then clamp to counter range.
  function automatic logic [LW-1:0] limit_of(input logic [REG_BITS-1:0] d,
                                             input logic min_one);
    logic [LW-1:0] v;
    v = LW'(d);
    if (min_one && (d == '0)) v = LW'(1);
    if (v > CMAX) v = CMAX;
    return v;
  endfunction

  assign tick_inc = tick_r + COUNT_BITS'(1);
  assign tick_cmp = LW'(tick_inc);

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    shift_nxt    = shift_r;
    bit_nxt      = bit_r;
    reading_nxt  = reading_r;
    presence_nxt = presence_r;
    done         = 1'b0;
    rej          = 1'b0;

    if (beat_en) begin
      if (beat.command != CMD_TICK) begin
        if (phase_r != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          tick_nxt = '0;
          bit_nxt  = '0;
          if (beat.command == CMD_RESET) begin
            phase_nxt = PH_RST_LOW;
          end else begin
            phase_nxt   = PH_SLOT_LOW;
            reading_nxt = (beat.command == CMD_READ);
            shift_nxt   = (beat.command == CMD_WRITE) ? beat.data_byte : 8'h00;
          end
        end
      end else if (phase_r != PH_IDLE) begin
        tick_nxt = tick_inc;
        case (phase_r)
          PH_RST_LOW: begin
            if (tick_cmp >= limit_of(cfg.reset_low_time, 1'b1)) begin
              phase_nxt = PH_RST_WAIT;
              tick_nxt  = '0;
            end
          end
          PH_RST_WAIT: begin
            if (tick_cmp >= limit_of(cfg.presence_wait, 1'b1)) begin
              presence_nxt = ~beat.line_level;
              tick_nxt     = '0;
              if (limit_of(cfg.reset_tail, 1'b0) == '0) begin
                phase_nxt = PH_IDLE;
                done      = 1'b1;
              end else begin
                phase_nxt = PH_RST_TAIL;
              end
            end
          end
          PH_RST_TAIL: begin
            if (tick_cmp >= limit_of(cfg.reset_tail, 1'b0)) begin
              phase_nxt = PH_IDLE;
              tick_nxt  = '0;
              done      = 1'b1;
            end
          end
          PH_SLOT_LOW: begin
            if (tick_cmp >= limit_of(cfg.slot_low_time, 1'b1)) begin
              phase_nxt = PH_SLOT_MID;
              tick_nxt  = '0;
            end
          end
          PH_SLOT_MID: begin
            if (reading_r) begin
              if (tick_cmp >= limit_of(cfg.read_sample_delay, 1'b1)) begin
                shift_nxt = {beat.line_level, shift_r[7:1]};
                tick_nxt  = '0;
                if (limit_of(cfg.read_tail, 1'b0) == '0) begin
                  if (&bit_r) begin
                    bit_nxt   = '0;
                    phase_nxt = PH_IDLE;
                    done      = 1'b1;
                  end else begin
                    bit_nxt   = bit_r + 3'd1;
                    phase_nxt = PH_SLOT_LOW;
                  end
                end else begin
                  phase_nxt = PH_READ_TAIL;
                end
              end
            end else if (tick_cmp >= limit_of(cfg.write_hold, 1'b1)) begin
              shift_nxt = {1'b0, shift_r[7:1]};
              tick_nxt  = '0;
              if (&bit_r) begin
                bit_nxt   = '0;
                phase_nxt = PH_IDLE;
                done      = 1'b1;
              end else begin
                bit_nxt   = bit_r + 3'd1;
                phase_nxt = PH_SLOT_LOW;
              end
            end
          end
          PH_READ_TAIL: begin
            if (tick_cmp >= limit_of(cfg.read_tail, 1'b0)) begin
              tick_nxt = '0;
              if (&bit_r) begin
                bit_nxt   = '0;
                phase_nxt = PH_IDLE;
                done      = 1'b1;
              end else begin
                bit_nxt   = bit_r + 3'd1;
                phase_nxt = PH_SLOT_LOW;
              end
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            tick_nxt  = '0;
          end
        endcase
      end
    end
  end

  // Result reflects the state after this beat.
  always_comb begin
    res.drive_low = (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_SLOT_LOW) ||
                    ((phase_nxt == PH_SLOT_MID) && !reading_nxt && !shift_nxt[0]);
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.presence  = presence_nxt;
    res.read_data = (done && (phase_nxt == PH_IDLE) && reading_nxt) ? shift_nxt : 8'h00;
    res.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tick_r     <= '0;
      shift_r    <= '0;
      bit_r      <= '0;
      reading_r  <= 1'b0;
      presence_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      shift_r    <= shift_nxt;
      bit_r      <= bit_nxt;
      reading_r  <= reading_nxt;
      presence_r <= presence_nxt;
    end
  end

endmodule

>>> src/one_wire_bus_master.sv
`timescale 1ns / 1ps
// Top level: 1-Wire bus master with input stage, sequencer and result register.
//
//   channel  direction  handshake            payload
//   in_      sink       in_valid / in_ready  owb_in_t  (command, data_byte, line_level)
//   out_     source     out_valid/out_ready  owb_out_t (drive, busy, done, presence, ...)
//   cfg_     sink       cfg_wr_en only       cfg_index, cfg_wdata (10-bit tick counts)
//
// Every input beat yields exactly one result beat. A beat is registered in the
// input stage, crosses the combinational sequencer and lands in the result
// register once that register is free, and its result is offered from there;
// one beat is taken per clock while out_ready stays high.
// The sequencer state advances only when the input stage hands a beat on.
// Reset (rst_n low, synchronous) idles the sequencer, empties both stages and
// loads the timing registers with their defaults.
// A stalled result holds the result register; the input stage still takes one
// more beat and then holds too, so no beat is lost while out_ready is low.
module one_wire_bus_master #(
  parameter int COUNT_BITS = owb_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input beats
  input  logic                          in_valid,
  output logic                          in_ready,
  input  owb_pkg::owb_in_t              in_data,
  // result beats
  output logic                          out_valid,
  input  logic                          out_ready,
  output owb_pkg::owb_out_t             out_data,
  // timing register writes
  input  logic                          cfg_wr_en,
  input  logic [owb_pkg::IDX_BITS-1:0]  cfg_index,
  input  logic [owb_pkg::REG_BITS-1:0]  cfg_wdata
);
  import owb_pkg::*;

  owb_cfg_t cfg;

  logic     s1_valid_r, s1_valid_nxt;
  owb_in_t  s1_data_r;
  logic     out_valid_r, out_valid_nxt;
  owb_out_t out_data_r;
  owb_out_t res;

  logic     out_free;
  logic     s1_fire;
  logic     in_fire;

  owb_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  owb_engine #(
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat_en (s1_fire),
    .beat    (s1_data_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_ready;
  // Advance the staged beat through the sequencer into the result register.
  assign s1_fire  = s1_valid_r && out_free;
  // Take a new beat whenever the input stage empties or moves on.
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on handoff, otherwise hold.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
